@@ hw/rtl/srsp_pkg.sv @@
// Shared types, constants and codes of the schema record stream parser.
`timescale 1ns / 1ps
package srsp_pkg;

    localparam int MAX_FIELDS    = 64;
    localparam int FIELD_BITS    = $clog2(MAX_FIELDS);
    localparam int POSITION_BITS = 23;
    localparam int QUEUE_DEPTH   = 8;

    typedef enum logic [3:0] {
        KIND_VALUE    = 4'd0,
        KIND_LCOUNT   = 4'd1,
        KIND_LID      = 4'd2,
        KIND_LRECORD  = 4'd3,
        KIND_LTIME    = 4'd4,
        KIND_RCOUNT   = 4'd5,
        KIND_SCHEMA   = 4'd6,
        KIND_ERROR    = 4'd7,
        KIND_END      = 4'd8
    } item_kind_t;

    typedef enum logic [3:0] {
        ERR_NONE       = 4'd0,
        ERR_SHORT_CNT  = 4'd1,
        ERR_TOO_MANY   = 4'd2,
        ERR_NAME_LEN   = 4'd3,
        ERR_NAME_CHAR  = 4'd4,
        ERR_BAD_TYPE   = 4'd5,
        ERR_SHORT_HDR  = 4'd6,
        ERR_TRUNC      = 4'd7,
        ERR_IP_VER     = 4'd8,
        ERR_NEG_LEN    = 4'd9,
        ERR_INCOMPLETE = 4'd10
    } err_code_t;

    typedef struct packed {
        logic                     last;
        logic [POSITION_BITS-1:0] pos;
        err_code_t                err;
        logic [63:0]              value;
        logic [3:0]               fkind;
        logic [5:0]               fnum;
        item_kind_t               kind;
    } item_t;

    // Up to two result items a cycle from the parser into the queue
    typedef struct packed {
        logic [1:0]      count;
        item_t [1:0]     items;
    } push_t;

    function automatic item_t mk_item(item_kind_t k, logic [5:0] fn, logic [3:0] fk,
                                      logic [63:0] v, err_code_t e,
                                      logic [POSITION_BITS-1:0] p, logic l);
        item_t it;
        it.kind  = k;
        it.fnum  = fn;
        it.fkind = fk;
        it.value = v;
        it.err   = e;
        it.pos   = p;
        it.last  = l;
        return it;
    endfunction

endpackage

@@ hw/rtl/srsp_ram.sv @@
// Generic single-port-write, registered-read RAM.
`timescale 1ns / 1ps
module srsp_ram #(
    parameter int WIDTH = 4,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

@@ hw/rtl/srsp_queue.sv @@
// Result queue: takes up to two items a cycle, hands out one.
`timescale 1ns / 1ps
module srsp_queue
    import srsp_pkg::*;
(
    input  logic  aclk,
    input  logic  aresetn,
    input  push_t push,
    output logic  space_ok,
    output logic  out_valid,
    input  logic  out_ready,
    output item_t out_item
);
    localparam int PW = $clog2(QUEUE_DEPTH);

    item_t           mem_reg [QUEUE_DEPTH];
    logic [PW-1:0]   wptr_reg, rptr_reg;
    logic [PW:0]     cnt_reg, cnt_next;
    logic            pop;

    assign out_valid = (cnt_reg != '0);
    assign out_item  = mem_reg[rptr_reg];
    assign pop       = out_valid && out_ready;
    assign space_ok  = (cnt_reg <= (PW+1)'(QUEUE_DEPTH - 2));
    assign cnt_next  = cnt_reg + (PW+1)'(push.count) - (PW+1)'(pop);

    always_ff @(posedge aclk) begin
        if (push.count != 2'd0) begin
            mem_reg[wptr_reg] <= push.items[0];
        end
        if (push.count == 2'd2) begin
            mem_reg[wptr_reg + PW'(1)] <= push.items[1];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            cnt_reg  <= '0;
        end else begin
            wptr_reg <= wptr_reg + PW'(push.count);
            if (pop) begin
                rptr_reg <= rptr_reg + PW'(1);
            end
            cnt_reg <= cnt_next;
        end
    end
endmodule

@@ hw/rtl/srsp_core.sv @@
// Byte parser: schema, link header and records, type table in RAM.
`timescale 1ns / 1ps
module srsp_core
    import srsp_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [7:0]  cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  in_byte,
    input  logic        in_last,
    input  logic        space_ok,
    output push_t       push
);
    typedef enum logic [3:0] {
        PH_COUNT, PH_NAMELEN, PH_NAME, PH_TYPE, PH_HDR, PH_REC,
        PH_VAL, PH_LEN7, PH_LEN11, PH_SKIP, PH_DONE
    } phase_t;

    phase_t                   ph_reg, ph_next;
    logic [6:0]               fr_reg, fr_next;
    logic [6:0]               fs_reg, fs_next;
    logic [31:0]              ebl_reg, ebl_next;
    logic [63:0]              acc_reg, acc_next;
    logic [FIELD_BITS-1:0]    cf_reg, cf_next;
    logic [31:0]              rr_reg, rr_next;
    logic [POSITION_BITS-1:0] pos_reg, pos_next;
    logic                     err_reg, err_next;
    err_code_t                code_reg, code_next;
    logic                     endp_reg, endp_next;
    logic [7:0]               mnl_reg;

    logic                     we;
    logic [FIELD_BITS-1:0]    waddr;
    logic [3:0]               ram_q;
    logic [3:0]               ct;
    logic                     accept;

    assign in_ready = !endp_reg && space_ok;
    assign accept   = in_valid && in_ready;
    // entry of the current field; address follows cf_next so data is ready
    assign ct       = ({1'b0, cf_reg} < fs_reg) ? ram_q : 4'd0;

    srsp_ram #(.WIDTH(4), .DEPTH(MAX_FIELDS)) u_types (
        .aclk  (aclk),
        .we    (we),
        .waddr (waddr),
        .wdata (in_byte[3:0]),
        .raddr (cf_next),
        .rdata (ram_q)
    );

    always_comb begin
        logic        fd;
        logic [63:0] fd_val;
        logic [63:0] an;
        logic [4:0]  k;
        logic [31:0] v;
        err_code_t   ec;
        ph_next = ph_reg;   fr_next = fr_reg;   fs_next = fs_reg;
        ebl_next = ebl_reg; acc_next = acc_reg; cf_next = cf_reg;
        rr_next = rr_reg;   pos_next = pos_reg; err_next = err_reg;
        code_next = code_reg; endp_next = endp_reg;
        push = '0; we = 1'b0; waddr = fs_reg[FIELD_BITS-1:0];
        fd = 1'b0; fd_val = '0;
        an = {acc_reg[55:0], in_byte};
        k = 5'd19 - ebl_reg[4:0];
        v = '0; ec = ERR_NONE;

        if (endp_reg) begin
            if (space_ok) begin
                ec = code_reg;
                if (!err_reg) begin
                    case (ph_reg)
                        PH_COUNT:   ec = ERR_SHORT_CNT;
                        PH_NAMELEN: ec = (ebl_reg == 32'd4 && fr_reg != '0) ?
                                         ERR_INCOMPLETE : ERR_TRUNC;
                        PH_NAME, PH_TYPE: ec = ERR_TRUNC;
                        PH_HDR:     ec = ERR_SHORT_HDR;
                        PH_REC:     ec = (cf_reg != '0) ? ERR_TRUNC : ERR_NONE;
                        PH_DONE:    ec = ERR_NONE;
                        default:    ec = ERR_TRUNC;
                    endcase
                end
                if (!err_reg && ec != ERR_NONE) begin
                    push.items[0] = mk_item(KIND_ERROR,
                        (ph_reg <= PH_TYPE) ? fs_reg[5:0] : 6'(cf_reg),
                        (ph_reg >= PH_REC) ? ct : 4'd0, '0, ec, pos_reg, 1'b0);
                    push.items[1] = mk_item(KIND_END, '0, '0, 64'(rr_reg), ec,
                                            pos_reg, 1'b1);
                    push.count = 2'd2;
                end else begin
                    push.items[0] = mk_item(KIND_END, '0, '0, 64'(rr_reg), ec,
                                            pos_reg, 1'b1);
                    push.count = 2'd1;
                end
                ph_next = PH_COUNT; fr_next = '0; fs_next = '0; ebl_next = 32'd2;
                acc_next = '0; cf_next = '0; rr_next = '0; pos_next = '0;
                err_next = 1'b0; code_next = ERR_NONE; endp_next = 1'b0;
            end
        end else if (accept) begin
            if (!err_reg) begin
                case (ph_reg)
                    PH_COUNT: begin
                        acc_next = an;
                        ebl_next = ebl_reg - 32'd1;
                        if (ebl_reg == 32'd1) begin
                            if (an[15:0] > 16'(MAX_FIELDS)) begin
                                ec = ERR_TOO_MANY;
                                push.items[0] = mk_item(KIND_ERROR, '0, '0,
                                    64'(an[15:0]), ec, pos_reg, 1'b0);
                            end else begin
                                fr_next = an[6:0];
                                fs_next = '0;
                                acc_next = '0;
                                if (an[15:0] == '0) begin
                                    ph_next = PH_HDR; ebl_next = 32'd19;
                                end else begin
                                    ph_next = PH_NAMELEN; ebl_next = 32'd4;
                                end
                            end
                        end
                    end
                    PH_NAMELEN: begin
                        acc_next = an;
                        ebl_next = ebl_reg - 32'd1;
                        if (ebl_reg == 32'd1) begin
                            v = an[31:0];
                            if (v == '0 || v > 32'(mnl_reg)) begin
                                ec = ERR_NAME_LEN;
                                push.items[0] = mk_item(KIND_ERROR, fs_reg[5:0], '0,
                                    64'(v), ec, pos_reg, 1'b0);
                            end else begin
                                ebl_next = v;
                                acc_next = 64'(v);
                                ph_next = PH_NAME;
                            end
                        end
                    end
                    PH_NAME: begin
                        if (!(in_byte == 8'h00 || (in_byte >= 8'h20 && in_byte <= 8'h7E)))
                        begin
                            ec = ERR_NAME_CHAR;
                            push.items[0] = mk_item(KIND_ERROR, fs_reg[5:0], '0,
                                64'(in_byte), ec, pos_reg, 1'b0);
                        end else begin
                            ebl_next = ebl_reg - 32'd1;
                            if (ebl_reg == 32'd1) ph_next = PH_TYPE;
                        end
                    end
                    PH_TYPE: begin
                        if (in_byte < 8'd1 || in_byte > 8'd12 ||
                            fs_reg >= 7'(MAX_FIELDS)) begin
                            ec = ERR_BAD_TYPE;
                            push.items[0] = mk_item(KIND_ERROR, fs_reg[5:0], '0,
                                64'(in_byte), ec, pos_reg, 1'b0);
                        end else begin
                            we = 1'b1;
                            push.items[0] = mk_item(KIND_SCHEMA, fs_reg[5:0],
                                in_byte[3:0], acc_reg, ERR_NONE, pos_reg, 1'b0);
                            push.count = 2'd1;
                            fs_next = fs_reg + 7'd1;
                            fr_next = fr_reg - 7'd1;
                            acc_next = '0;
                            if (fr_reg == 7'd1) begin
                                ph_next = PH_HDR; ebl_next = 32'd19;
                            end else begin
                                ph_next = PH_NAMELEN; ebl_next = 32'd4;
                            end
                        end
                    end
                    PH_HDR: begin
                        ebl_next = ebl_reg - 32'd1;
                        acc_next = an;
                        if (k == 5'd0 || k == 5'd2 || k == 5'd6 || k == 5'd14 ||
                            k == 5'd18) begin
                            acc_next = '0;
                            push.count = 2'd1;
                            case (k)
                                5'd0:  push.items[0] = mk_item(KIND_LCOUNT, '0, '0, an,
                                           ERR_NONE, pos_reg, 1'b0);
                                5'd2:  push.items[0] = mk_item(KIND_LID, '0, '0, an,
                                           ERR_NONE, pos_reg, 1'b0);
                                5'd6:  push.items[0] = mk_item(KIND_LRECORD, '0, '0, an,
                                           ERR_NONE, pos_reg, 1'b0);
                                5'd14: push.items[0] = mk_item(KIND_LTIME, '0, '0, an,
                                           ERR_NONE, pos_reg, 1'b0);
                                default: begin
                                    push.items[0] = mk_item(KIND_RCOUNT, '0, '0, an,
                                        ERR_NONE, pos_reg, 1'b0);
                                    rr_next = an[31:0];
                                    cf_next = '0;
                                    ph_next = (an[31:0] == '0) ? PH_DONE : PH_REC;
                                end
                            endcase
                        end
                    end
                    PH_REC: begin
                        if (fs_reg == '0) begin
                            rr_next = '0;
                            ph_next = PH_DONE;
                        end else begin
                            if (cf_reg == '0) rr_next = rr_reg - 32'd1;
                            acc_next = 64'(in_byte);
                            case (ct)
                                4'd1, 4'd12: begin fd = 1'b1; fd_val = 64'(in_byte); end
                                4'd2: begin ebl_next = 32'd1; ph_next = PH_VAL; end
                                4'd3, 4'd8: begin ebl_next = 32'd3; ph_next = PH_VAL; end
                                4'd4, 4'd5, 4'd6, 4'd9: begin
                                    ebl_next = 32'd7; ph_next = PH_VAL;
                                end
                                4'd7:  begin ebl_next = 32'd3; ph_next = PH_LEN7; end
                                4'd11: begin ebl_next = 32'd3; ph_next = PH_LEN11; end
                                4'd10: begin
                                    if (in_byte == 8'd4 || in_byte == 8'd6) begin
                                        ebl_next = (in_byte == 8'd4) ? 32'd4 : 32'd16;
                                        ph_next = PH_SKIP;
                                    end else begin
                                        ec = ERR_IP_VER;
                                        push.items[0] = mk_item(KIND_ERROR, 6'(cf_reg),
                                            ct, 64'(in_byte), ec, pos_reg, 1'b0);
                                    end
                                end
                                default: begin
                                    ec = ERR_BAD_TYPE;
                                    push.items[0] = mk_item(KIND_ERROR, 6'(cf_reg), ct,
                                        64'(ct), ec, pos_reg, 1'b0);
                                end
                            endcase
                        end
                    end
                    PH_VAL: begin
                        acc_next = an;
                        ebl_next = ebl_reg - 32'd1;
                        if (ebl_reg == 32'd1) begin fd = 1'b1; fd_val = an; end
                    end
                    PH_LEN7, PH_LEN11: begin
                        if (ph_reg == PH_LEN7) begin
                            acc_next = an;
                        end else begin
                            acc_next = acc_reg;
                            case (ebl_reg[1:0])
                                2'd3:    acc_next[15:8]  = in_byte;
                                2'd2:    acc_next[23:16] = in_byte;
                                default: acc_next[31:24] = in_byte;
                            endcase
                        end
                        ebl_next = ebl_reg - 32'd1;
                        if (ebl_reg == 32'd1) begin
                            v = acc_next[31:0];
                            if (ph_reg == PH_LEN11 && v[31]) begin
                                ec = ERR_NEG_LEN;
                                push.items[0] = mk_item(KIND_ERROR, 6'(cf_reg), ct,
                                    64'(v), ec, pos_reg, 1'b0);
                            end else if (v == '0) begin
                                fd = 1'b1;
                            end else begin
                                ebl_next = v;
                                acc_next = 64'(v);
                                ph_next = PH_SKIP;
                            end
                        end
                    end
                    PH_SKIP: begin
                        ebl_next = ebl_reg - 32'd1;
                        if (ebl_reg == 32'd1) begin fd = 1'b1; fd_val = acc_reg; end
                    end
                    default: ;
                endcase
                if (ec != ERR_NONE) begin
                    push.count = 2'd1;
                    err_next = 1'b1;
                    code_next = ec;
                end
                if (fd) begin
                    push.items[0] = mk_item(KIND_VALUE, 6'(cf_reg), ct, fd_val,
                                            ERR_NONE, pos_reg, 1'b0);
                    push.count = 2'd1;
                    if ({1'b0, cf_reg} + 7'd1 >= fs_reg) begin
                        cf_next = '0;
                        ph_next = (rr_next == '0) ? PH_DONE : PH_REC;
                    end else begin
                        cf_next = cf_reg + FIELD_BITS'(1);
                        ph_next = PH_REC;
                    end
                end
            end
            if (in_last) endp_next = 1'b1;
            else pos_next = pos_reg + POSITION_BITS'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ph_reg <= PH_COUNT; fr_reg <= '0; fs_reg <= '0; ebl_reg <= 32'd2;
            acc_reg <= '0; cf_reg <= '0; rr_reg <= '0; pos_reg <= '0;
            err_reg <= 1'b0; code_reg <= ERR_NONE; endp_reg <= 1'b0;
            mnl_reg <= 8'd254;
        end else begin
            ph_reg <= ph_next; fr_reg <= fr_next; fs_reg <= fs_next;
            ebl_reg <= ebl_next; acc_reg <= acc_next; cf_reg <= cf_next;
            rr_reg <= rr_next; pos_reg <= pos_next; err_reg <= err_next;
            code_reg <= code_next; endp_reg <= endp_next;
            if (cfg_we) mnl_reg <= cfg_data;
        end
    end
endmodule

@@ hw/rtl/schema_record_stream_parser.sv @@
// Top level of the schema record stream parser.
`timescale 1ns / 1ps
// Parses a payload one byte per request: a big-endian schema (field count, names, types),
// a 19-byte link header, then records decoded against the stored type table. Each byte
// is taken while the queue has room and makes at most one result; after the last byte of
// a payload a separate end step, in which no byte is taken, sends the end check and the
// end summary (m_tlast). Results pass through an 8-entry queue, so bytes keep flowing
// while results wait; s_tready drops when fewer than two queue entries are free. The type
// table sits in a 64-entry RAM whose registered read is addressed with the next field.
// cfg_data (max name length) may be written only while the block is idle.
module schema_record_stream_parser
    import srsp_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [7:0]   cfg_data,     // max_name_length
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [7:0]   s_tdata,      // data_byte
    input  logic         s_tlast,      // last_byte
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [103:0] m_tdata,      // field_number, field_kind, item_value,
                                       // error_code, byte_position, zero pad
    output logic [3:0]   m_tuser,      // item_kind
    output logic         m_tlast       // last_item
);
    push_t push;
    logic  space_ok;
    item_t it;

    assign cfg_ready = 1'b1;

    srsp_core u_core (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_we   (cfg_valid),
        .cfg_data (cfg_data),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .in_byte  (s_tdata),
        .in_last  (s_tlast),
        .space_ok (space_ok),
        .push     (push)
    );

    srsp_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .space_ok  (space_ok),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_item  (it)
    );

    assign m_tdata = {3'b000, it.pos, it.err, it.value, it.fkind, it.fnum};
    assign m_tuser = it.kind;
    assign m_tlast = it.last;
endmodule

@@ hw/rtl/srsp_checker.sv @@
// Port-level assertions for the schema record stream parser, bound to the top.
`timescale 1ns / 1ps
module srsp_port_checker
    import srsp_pkg::*;
(
    input logic         aclk,
    input logic         aresetn,
    input logic         s_tvalid,
    input logic         s_tready,
    input logic         s_tlast,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [103:0] m_tdata,
    input logic [3:0]   m_tuser,
    input logic         m_tlast
);
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result dropped while stalled");

    a_last_kind: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tlast |-> m_tuser == KIND_END)
        else $error("tlast on a result that is not the end summary");

    a_end_gap: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && s_tlast |=> !s_tready)
        else $error("byte taken during end of payload");

    a_err_kind: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[77:74] != 4'd0 |-> m_tuser == KIND_ERROR || m_tuser == KIND_END)
        else $error("error code on a plain result");
endmodule

bind schema_record_stream_parser srsp_port_checker u_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

@@ dv/srsp_checker.sv @@
// Checker for the schema record stream parser: predicts results and compares them.
`timescale 1ns / 1ps
module srsp_checker
    import srsp_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         cfg_valid,
    input  logic         cfg_ready,
    input  logic [7:0]   cfg_data,
    input  logic         s_tvalid,
    input  logic         s_tready,
    input  logic [7:0]   s_tdata,
    input  logic         s_tlast,
    input  logic         m_tvalid,
    input  logic         m_tready,
    input  logic [103:0] m_tdata,
    input  logic [3:0]   m_tuser,
    input  logic         m_tlast,
    output int           fail_count,
    output int           pending
);

    typedef enum int {
        PH_COUNT, PH_NAMELEN, PH_NAME, PH_TYPE, PH_HDR, PH_REC,
        PH_VAL, PH_LEN7, PH_LEN11, PH_SKIP, PH_DONE
    } parse_phase_t;

    item_t                    expected_items[$];
    logic [7:0]               name_max;
    parse_phase_t             phase;
    int unsigned              fields_left;
    int unsigned              fields_stored;
    logic [3:0]               type_table[MAX_FIELDS];
    int unsigned              bytes_left;
    logic [63:0]              acc;
    int unsigned              cur_field;
    logic [31:0]              records_left;
    logic [POSITION_BITS-1:0] position;
    bit                       halted;
    err_code_t                latched_err;

    function automatic void push_item(item_kind_t k, int unsigned fn, int unsigned fk,
                                      logic [63:0] v, err_code_t e, logic l);
        item_t it;
        it.kind  = k;
        it.fnum  = fn[5:0];
        it.fkind = fk[3:0];
        it.value = v;
        it.err   = e;
        it.pos   = position;
        it.last  = l;
        expected_items.insert(expected_items.size(), it);
    endfunction

    function automatic void stop_parse(err_code_t e, int unsigned fn, int unsigned fk,
                                       logic [63:0] v);
        halted      = 1'b1;
        latched_err = e;
        push_item(KIND_ERROR, fn, fk, v, e, 1'b0);
    endfunction

    function automatic int unsigned field_type();
        return (cur_field < fields_stored) ? 32'(type_table[cur_field]) : 32'd0;
    endfunction

    function automatic void clear_state();
        phase         = PH_COUNT;
        fields_left   = 0;
        fields_stored = 0;
        bytes_left    = 2;
        acc           = '0;
        cur_field     = 0;
        records_left  = '0;
        position      = '0;
        halted        = 1'b0;
        latched_err   = ERR_NONE;
    endfunction

    function automatic void value_done(logic [63:0] v);
        push_item(KIND_VALUE, cur_field, field_type(), v, ERR_NONE, 1'b0);
        cur_field++;
        if (cur_field >= fields_stored) begin
            cur_field = 0;
            phase = (records_left == 0) ? PH_DONE : PH_REC;
        end else begin
            phase = PH_REC;
        end
    endfunction

    function automatic void next_name();
        phase      = PH_NAMELEN;
        bytes_left = 4;
        acc        = '0;
    endfunction

    function automatic void next_header();
        phase      = PH_HDR;
        bytes_left = 19;
        acc        = '0;
    endfunction

    function automatic void record_start(logic [7:0] b);
        int unsigned t;
        if (fields_stored == 0) begin
            records_left = '0;
            phase = PH_DONE;
            return;
        end
        if (cur_field == 0)
            records_left--;
        t   = field_type();
        acc = {56'd0, b};
        case (t)
            1, 12:        value_done({56'd0, b});
            2:            begin bytes_left = 1; phase = PH_VAL; end
            3, 8:         begin bytes_left = 3; phase = PH_VAL; end
            4, 5, 6, 9:   begin bytes_left = 7; phase = PH_VAL; end
            7:            begin bytes_left = 3; phase = PH_LEN7; end
            11:           begin bytes_left = 3; phase = PH_LEN11; end
            10: begin
                if (b == 8'd4 || b == 8'd6) begin
                    bytes_left = (b == 8'd4) ? 4 : 16;
                    phase = PH_SKIP;
                end else begin
                    stop_parse(ERR_IP_VER, cur_field, t, {56'd0, b});
                end
            end
            default:      stop_parse(ERR_BAD_TYPE, cur_field, t, 64'(t));
        endcase
    endfunction

    function automatic void parse_byte(logic [7:0] b);
        int unsigned k;
        logic [63:0] v;
        case (phase)
            PH_COUNT: begin
                acc = (acc << 8) | {56'd0, b};
                bytes_left--;
                if (bytes_left == 0) begin
                    v = acc & 64'hFFFF;
                    if (v > MAX_FIELDS) begin
                        stop_parse(ERR_TOO_MANY, 0, 0, v);
                    end else begin
                        fields_left   = 32'(v);
                        fields_stored = 0;
                        if (v == 0) next_header(); else next_name();
                    end
                end
            end
            PH_NAMELEN: begin
                acc = (acc << 8) | {56'd0, b};
                bytes_left--;
                if (bytes_left == 0) begin
                    v = acc & 64'hFFFF_FFFF;
                    if (v == 0 || v > 64'(name_max)) begin
                        stop_parse(ERR_NAME_LEN, fields_stored, 0, v);
                    end else begin
                        bytes_left = 32'(v);
                        acc        = v;
                        phase      = PH_NAME;
                    end
                end
            end
            PH_NAME: begin
                if (!(b == 8'h00 || (b >= 8'h20 && b <= 8'h7E))) begin
                    stop_parse(ERR_NAME_CHAR, fields_stored, 0, {56'd0, b});
                end else begin
                    bytes_left--;
                    if (bytes_left == 0) phase = PH_TYPE;
                end
            end
            PH_TYPE: begin
                if (b < 1 || b > 12 || fields_stored >= MAX_FIELDS) begin
                    stop_parse(ERR_BAD_TYPE, fields_stored, 0, {56'd0, b});
                end else begin
                    type_table[fields_stored] = b[3:0];
                    push_item(KIND_SCHEMA, fields_stored, 32'(b), acc, ERR_NONE, 1'b0);
                    fields_stored++;
                    fields_left--;
                    if (fields_left == 0) next_header(); else next_name();
                end
            end
            PH_HDR: begin
                k = 19 - bytes_left;
                bytes_left--;
                acc = (acc << 8) | {56'd0, b};
                if (k == 0 || k == 2 || k == 6 || k == 14 || k == 18) begin
                    v   = acc;
                    acc = '0;
                    case (k)
                        0:  push_item(KIND_LCOUNT, 0, 0, v, ERR_NONE, 1'b0);
                        2:  push_item(KIND_LID, 0, 0, v, ERR_NONE, 1'b0);
                        6:  push_item(KIND_LRECORD, 0, 0, v, ERR_NONE, 1'b0);
                        14: push_item(KIND_LTIME, 0, 0, v, ERR_NONE, 1'b0);
                        default: begin
                            push_item(KIND_RCOUNT, 0, 0, v, ERR_NONE, 1'b0);
                            records_left = v[31:0];
                            cur_field    = 0;
                            phase = (records_left == 0) ? PH_DONE : PH_REC;
                        end
                    endcase
                end
            end
            PH_REC: record_start(b);
            PH_VAL: begin
                acc = (acc << 8) | {56'd0, b};
                bytes_left--;
                if (bytes_left == 0) value_done(acc);
            end
            PH_LEN7, PH_LEN11: begin
                if (phase == PH_LEN7)
                    acc = (acc << 8) | {56'd0, b};
                else
                    acc = acc | ({56'd0, b} << (8 * (4 - bytes_left)));
                bytes_left--;
                if (bytes_left == 0) begin
                    v = acc & 64'hFFFF_FFFF;
                    if (phase == PH_LEN11 && v[31]) begin
                        stop_parse(ERR_NEG_LEN, cur_field, field_type(), v);
                    end else if (v == 0) begin
                        value_done('0);
                    end else begin
                        bytes_left = 32'(v);
                        acc        = v;
                        phase      = PH_SKIP;
                    end
                end
            end
            PH_SKIP: begin
                bytes_left--;
                if (bytes_left == 0) value_done(acc);
            end
            default: ;
        endcase
    endfunction

    function automatic err_code_t end_check();
        case (phase)
            PH_COUNT:         return ERR_SHORT_CNT;
            PH_NAMELEN:       return (bytes_left == 4 && fields_left > 0) ?
                                     ERR_INCOMPLETE : ERR_TRUNC;
            PH_NAME, PH_TYPE: return ERR_TRUNC;
            PH_HDR:           return ERR_SHORT_HDR;
            PH_REC:           return (cur_field != 0) ? ERR_TRUNC : ERR_NONE;
            PH_DONE:          return ERR_NONE;
            default:          return ERR_TRUNC;
        endcase
    endfunction

    function automatic void predict_byte(logic [7:0] b, logic l);
        err_code_t e;
        if (!halted)
            parse_byte(b);
        if (l) begin
            if (!halted) begin
                e = end_check();
                if (e != ERR_NONE)
                    stop_parse(e, (phase <= PH_TYPE) ? fields_stored : cur_field,
                               (phase >= PH_REC) ? field_type() : 32'd0, '0);
            end
            push_item(KIND_END, 0, 0, {32'd0, records_left}, latched_err, 1'b1);
            clear_state();
        end else begin
            position = position + POSITION_BITS'(1);
        end
    endfunction

    always @(posedge aclk) begin
        item_t exp_it;
        if (!aresetn) begin
            name_max = 8'd254;
            clear_state();
            expected_items.delete();
            fail_count = 0;
        end else begin
            if (cfg_valid && cfg_ready)
                name_max = cfg_data;
            if (s_tvalid && s_tready)
                predict_byte(s_tdata, s_tlast);
            if (m_tvalid && m_tready) begin
                if (expected_items.size() == 0) begin
                    $error("result with nothing expected: kind %0d", m_tuser);
                    fail_count++;
                end else begin
                    exp_it = expected_items.pop_front();
                    if (m_tuser != exp_it.kind) begin
                        $error("item_kind exp %0d got %0d", exp_it.kind, m_tuser);
                        fail_count++;
                    end
                    if (m_tdata[5:0] != exp_it.fnum) begin
                        $error("field_number exp %0d got %0d", exp_it.fnum, m_tdata[5:0]);
                        fail_count++;
                    end
                    if (m_tdata[9:6] != exp_it.fkind) begin
                        $error("field_kind exp %0d got %0d", exp_it.fkind, m_tdata[9:6]);
                        fail_count++;
                    end
                    if (m_tdata[73:10] != exp_it.value) begin
                        $error("item_value exp %h got %h", exp_it.value, m_tdata[73:10]);
                        fail_count++;
                    end
                    if (m_tdata[77:74] != exp_it.err) begin
                        $error("error_code exp %0d got %0d", exp_it.err, m_tdata[77:74]);
                        fail_count++;
                    end
                    if (m_tdata[100:78] != exp_it.pos) begin
                        $error("byte_position exp %0d got %0d", exp_it.pos, m_tdata[100:78]);
                        fail_count++;
                    end
                    if (m_tlast != exp_it.last) begin
                        $error("last_item exp %0d got %0d", exp_it.last, m_tlast);
                        fail_count++;
                    end
                end
            end
        end
        pending = expected_items.size();
    end

endmodule

@@ dv/tb_top.sv @@
// Testbench top: stimulus, receiver stalls, watchdog and verdict for the parser.
`timescale 1ns / 1ps
module tb_top;
    import srsp_pkg::*;

    localparam int IDLE_LIMIT  = 2000;
    localparam int ITEM_TARGET = 110;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         cfg_valid = 1'b0;
    logic         cfg_ready;
    logic [7:0]   cfg_data = 8'd0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [7:0]   s_tdata = 8'd0;
    logic         s_tlast = 1'b0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [103:0] m_tdata;
    logic [3:0]   m_tuser;
    logic         m_tlast;
    int           fail_count;
    int           pending;

    logic [7:0]   payload[$];
    logic [3:0]   field_types[$];
    logic [7:0]   name_max = 8'd254;
    bit           burst;
    bit           long_hold = 1'b0;
    int           idle_cycles = 0;
    int           bytes_sent = 0;

    always #4 aclk = ~aclk;

    schema_record_stream_parser dut (.*);
    srsp_checker checker_i (.*);

    function automatic void add_byte(input logic [7:0] b);
        payload.insert(payload.size(), b);
    endfunction

    // Builds a payload for the types in field_types; its record count is sometimes random
    task automatic make_payload(input int nrec, input int name_len);
        int n;
        int len;
        logic [31:0] rc;
        logic [3:0] t;
        payload.delete();
        n = field_types.size();
        add_byte(8'(n >> 8));
        add_byte(8'(n));
        foreach (field_types[i]) begin
            len = (name_len > 0) ? name_len :
                  int'($urandom_range(1, (name_max < 8'd3) ? 32'(name_max) : 32'd3));
            add_byte(8'd0); add_byte(8'd0);
            add_byte(8'd0); add_byte(8'(len));
            repeat (len) add_byte(($urandom_range(0, 7) == 0) ? 8'h00 :
                                  8'($urandom_range(8'h20, 8'h7E)));
            add_byte(8'(field_types[i]));
        end
        rc = ($urandom_range(0, 9) == 0) ? $urandom() : 32'(nrec);
        repeat (15) add_byte(8'($urandom_range(0, 255)));
        for (int i = 3; i >= 0; i--) add_byte(rc[8*i +: 8]);
        if (n == 0) begin
            if (nrec > 0) repeat ($urandom_range(1, 3)) add_byte(8'($urandom_range(0, 255)));
            return;
        end
        repeat (nrec) begin
            foreach (field_types[i]) begin
                t = field_types[i];
                case (t)
                    4'd1, 4'd12: add_byte(8'($urandom_range(0, 255)));
                    4'd2:        repeat (2) add_byte(8'($urandom_range(0, 255)));
                    4'd3, 4'd8:  repeat (4) add_byte(8'($urandom_range(0, 255)));
                    4'd7, 4'd11: begin
                        len = int'($urandom_range(0, 3));
                        if (t == 4'd7) begin
                            add_byte(8'd0); add_byte(8'd0);
                            add_byte(8'd0); add_byte(8'(len));
                        end else begin
                            add_byte(8'(len)); add_byte(8'd0);
                            add_byte(8'd0); add_byte(8'd0);
                        end
                        repeat (len) add_byte(8'($urandom_range(0, 255)));
                    end
                    4'd10: begin
                        len = $urandom_range(0, 1) ? 4 : 6;
                        add_byte(8'(len));
                        repeat ((len == 4) ? 4 : 16) add_byte(8'($urandom_range(0, 255)));
                    end
                    default:     repeat (8) add_byte(8'($urandom_range(0, 255)));
                endcase
            end
        end
    endtask

    task automatic send_byte(input logic [7:0] b, input logic l);
        int gap;
        gap = burst ? 0 : $urandom_range(0, 15);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= l;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    task automatic send_payload(input bit fast);
        burst = fast || ($urandom_range(0, 2) == 0);
        foreach (payload[i]) send_byte(payload[i], i == payload.size() - 1);
        s_tvalid <= 1'b0;
        bytes_sent += payload.size();
        @(posedge aclk);
    endtask

    // Waits for the block to drain, then writes max name length
    task automatic write_name_max(input logic [7:0] v);
        while (pending != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        name_max = v;
    endtask

    task automatic one_field(input logic [3:0] t, input int nrec);
        field_types = {t};
        make_payload(nrec, 1);
    endtask

    // Receiver: random stalls per result, one long hold on request
    initial begin
        int w;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            w = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 15);
            if (long_hold) begin
                long_hold = 1'b0;
                w = 300;
            end
            if (w > 0) begin
                m_tready <= 1'b0;
                repeat (w) @(posedge aclk);
            end
            m_tready <= 1'b1;
            @(posedge aclk);
            while (!m_tvalid) @(posedge aclk);
        end
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles == IDLE_LIMIT) begin
                $display("end of test: mismatches");
                $finish;
            end
        end
    end

    initial begin
        int npay;
        int mode;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        write_name_max(8'd254);

        // directed: header only, count errors, name and type errors
        field_types.delete(); make_payload(0, 0); send_payload(1'b0);
        payload = {8'h00, 8'h41, 8'h12}; send_payload(1'b0);
        payload = {8'h00}; send_payload(1'b0);
        payload = {8'h00, 8'h01}; send_payload(1'b0);
        one_field(4'd1, 1); payload[5] = 8'h00; payload = payload[0:5]; send_payload(1'b0);
        one_field(4'd1, 1); payload[6] = 8'h1F; payload = payload[0:6]; send_payload(1'b0);
        one_field(4'd1, 1); payload[7] = 8'h0D; payload = payload[0:7]; send_payload(1'b0);

        // receiver holds off while a short payload with many results streams in
        one_field(4'd1, 3);
        long_hold = 1'b1;
        send_payload(1'b1);

        // random payloads with different name limits
        npay = 0;
        while (bytes_sent < ITEM_TARGET) begin
            if (npay % 2 == 0)
                write_name_max(8'($urandom_range(1, 254)));
            field_types.delete();
            repeat ($urandom_range(1, 2))
                field_types.insert(field_types.size(), 4'($urandom_range(1, 12)));
            make_payload(int'($urandom_range(0, 2)), 0);
            mode = $urandom_range(0, 9);
            if (mode == 7) begin
                payload = payload[0:$urandom_range(0, payload.size() - 1)];
            end else if (mode == 8) begin
                payload[$urandom_range(0, payload.size() - 1)] = 8'($urandom_range(0, 255));
            end else if (mode == 9) begin
                payload.delete();
                repeat ($urandom_range(1, 30)) add_byte(8'($urandom_range(0, 255)));
            end
            npay++;
            send_payload(1'b0);
        end

        while (pending != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
        if (fail_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
